>>> rtl/rgbxyz_pkg.sv
package rgbxyz_pkg;

  // fixed-point layout
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 3;
  localparam int CHAN_W         = 18;
  localparam int RES_W          = 17;
  localparam int ALPHA_W        = 16;
  localparam int PROD_W         = CHAN_W + COEF_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int RND_W          = SUM_W - 1 - COEF_FRAC_BITS;
  localparam int CFG_IDX_W      = 2;
  localparam int MICRO_ONE      = 1000000;
  localparam int MAX16          = 65535;

  typedef logic signed [CHAN_W-1:0]  chan_t;
  typedef logic        [RES_W-1:0]   res_t;
  typedef logic        [ALPHA_W-1:0] alpha_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION     = 2'd0,
    REG_ALPHA_PRESENT = 2'd1
  } cfg_reg_e;

  // per-beat control that enters the datapath
  typedef struct packed {
    logic valid;
    logic dir;
    logic alpha_en;
  } ctrl_t;

  // millionths to signed fixed point, round to nearest, ties away from zero
  function automatic coef_t to_fixed(input longint micro);
    longint mag;
    longint q;
    mag = (micro < 0) ? -micro : micro;
    q   = ((mag << COEF_FRAC_BITS) + MICRO_ONE / 2) / MICRO_ONE;
    return coef_t'((micro < 0) ? -q : q);
  endfunction

  // rgb to xyz rows, row major
  localparam coef_t FWD_COEF [9] = '{
    to_fixed(412453), to_fixed(357580), to_fixed(180423),
    to_fixed(212671), to_fixed(715160), to_fixed(72169),
    to_fixed(19334),  to_fixed(119193), to_fixed(950227)
  };

  // xyz to rgb rows, row major
  localparam coef_t REV_COEF [9] = '{
    to_fixed(3240479),  to_fixed(-1537150), to_fixed(-498535),
    to_fixed(-969256),  to_fixed(1875991),  to_fixed(41556),
    to_fixed(55648),    to_fixed(-204043),  to_fixed(1057311)
  };

  // saturate a signed channel to 0..65535
  function automatic alpha_t clamp_u16(input chan_t x);
    alpha_t r;
    if (x < 0) begin
      r = '0;
    end else if (x > chan_t'(MAX16)) begin
      r = alpha_t'(MAX16);
    end else begin
      r = x[ALPHA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/rgbxyz_datapath.sv
module rgbxyz_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rgbxyz_pkg::ctrl_t    ctrl_i,
  input  rgbxyz_pkg::chan_t    first_i,
  input  rgbxyz_pkg::chan_t    second_i,
  input  rgbxyz_pkg::chan_t    third_i,
  input  rgbxyz_pkg::chan_t    alpha_i,
  input  logic                 row_end_i,
  output logic                 valid_o,
  output rgbxyz_pkg::res_t     first_o,
  output rgbxyz_pkg::res_t     second_o,
  output rgbxyz_pkg::res_t     third_o,
  output rgbxyz_pkg::alpha_t   alpha_o,
  output logic                 row_end_o
);
  import rgbxyz_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

  chan_t                     in_v [3];
  chan_t                     s1_v_d [3];
  alpha_t                    s1_alpha_d;
  logic signed [PROD_W-1:0]  prod_d [9];
  logic signed [SUM_W-1:0]   sum_d [3];
  res_t                      res_d [3];

  // valid bits per stage
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  // payload per stage
  logic                      s1_dir_q, s2_dir_q, s3_dir_q;
  chan_t                     s1_v_q [3];
  logic signed [PROD_W-1:0]  s2_prod_q [9];
  logic signed [SUM_W-1:0]   s3_sum_q [3];
  res_t                      s4_res_q [3];
  alpha_t                    s1_alpha_q, s2_alpha_q, s3_alpha_q, s4_alpha_q;
  logic                      s1_row_q, s2_row_q, s3_row_q, s4_row_q;

  assign in_v[0] = first_i;
  assign in_v[1] = second_i;
  assign in_v[2] = third_i;

  // stage 1: saturate rgb inputs in the forward direction, clamp alpha, or force it to zero when disabled
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_v_d[i] = ctrl_i.dir ? in_v[i] : chan_t'({2'b00, clamp_u16(in_v[i])});
    end
    s1_alpha_d = ctrl_i.alpha_en ? clamp_u16(alpha_i) : '0;
  end

  // stage 2: nine products, coefficient chosen by direction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        prod_d[k*3+i] = PROD_W'(s1_v_q[i]) *
                        PROD_W'(s1_dir_q ? REV_COEF[k*3+i] : FWD_COEF[k*3+i]);
      end
    end
  end

  // stage 3: row sums plus half an lsb
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = SUM_W'(s2_prod_q[k*3]) + SUM_W'(s2_prod_q[k*3+1]) +
                 SUM_W'(s2_prod_q[k*3+2]) + HALF;
    end
  end

  // stage 4: drop fraction, negative to zero, clamp in reverse direction
  always_comb begin
    logic [RND_W-1:0] r;
    for (int k = 0; k < 3; k++) begin
      r = s3_sum_q[k][SUM_W-2:COEF_FRAC_BITS];
      if (s3_sum_q[k][SUM_W-1]) begin
        res_d[k] = '0;
      end else if (s3_dir_q && (|r[RND_W-1:ALPHA_W])) begin
        res_d[k] = res_t'(MAX16);
      end else begin
        res_d[k] = r[RES_W-1:0];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctrl_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // payload chain
  always_ff @(posedge clk_i) begin
    s1_dir_q   <= ctrl_i.dir;
    s1_v_q     <= s1_v_d;
    s1_alpha_q <= s1_alpha_d;
    s1_row_q   <= row_end_i;

    s2_dir_q   <= s1_dir_q;
    s2_prod_q  <= prod_d;
    s2_alpha_q <= s1_alpha_q;
    s2_row_q   <= s1_row_q;

    s3_dir_q   <= s2_dir_q;
    s3_sum_q   <= sum_d;
    s3_alpha_q <= s2_alpha_q;
    s3_row_q   <= s2_row_q;

    s4_res_q   <= res_d;
    s4_alpha_q <= s3_alpha_q;
    s4_row_q   <= s3_row_q;
  end

  assign valid_o   = s4_valid_q;
  assign first_o   = s4_res_q[0];
  assign second_o  = s4_res_q[1];
  assign third_o   = s4_res_q[2];
  assign alpha_o   = s4_alpha_q;
  assign row_end_o = s4_row_q;

`ifndef SYNTHESIS
  // every accepted beat comes out of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.valid |-> ##4 valid_o)
    else $error("beat lost in pipeline");

  // no result without an earlier accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(ctrl_i.valid, 4))
    else $error("result without input beat");

  // reverse results are clamped to 16 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(ctrl_i.dir, 4)) |->
      (!first_o[RES_W-1] && !second_o[RES_W-1] && !third_o[RES_W-1]))
    else $error("reverse result above 65535");

  // alpha disabled gives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !$past(ctrl_i.alpha_en, 4)) |-> (alpha_o == '0))
    else $error("alpha not zero while disabled");

  // row end travels with its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (row_end_o == $past(row_end_i, 4)))
    else $error("row end misaligned");
`endif

endmodule

>>> rtl/rgb16_xyz_color_matrix.sv
// channel   | direction | handshake               | content
// ----------+-----------+-------------------------+----------------------------------
// pixel in  | in        | start_i, busy_o         | in_first/second/third/alpha/row_end
// result    | out       | out_valid_o (strobe)    | out_first/second/third/alpha/row_end
// config    | in        | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// one pixel per clock; each beat leaves after it has passed through
// the four register stages (input clamp, multiply, row sum, round and clamp)
// busy_o stays low, so a beat can follow in every cycle
// reset clears the valid chain and both config registers (direction rgb to xyz,
// alpha disabled); results are strobed for one cycle and are never held off
module rgb16_xyz_color_matrix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  rgbxyz_pkg::chan_t     in_first_i,
  input  rgbxyz_pkg::chan_t     in_second_i,
  input  rgbxyz_pkg::chan_t     in_third_i,
  input  rgbxyz_pkg::chan_t     in_alpha_i,
  input  logic                  in_row_end_i,
  output logic                  out_valid_o,
  output rgbxyz_pkg::res_t      out_first_o,
  output rgbxyz_pkg::res_t      out_second_o,
  output rgbxyz_pkg::res_t      out_third_o,
  output rgbxyz_pkg::alpha_t    out_alpha_o,
  output logic                  out_row_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  rgbxyz_pkg::cfg_idx_t  cfg_index_i,
  input  logic                  cfg_data_i
);
  import rgbxyz_pkg::*;

  logic  direction_q, direction_d;
  logic  alpha_present_q, alpha_present_d;
  ctrl_t ctrl;

  // fully pipelined, always ready
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // config register writes
  always_comb begin
    direction_d     = direction_q;
    alpha_present_d = alpha_present_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DIRECTION:     direction_d     = cfg_data_i;
        REG_ALPHA_PRESENT: alpha_present_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q     <= 1'b0;
      alpha_present_q <= 1'b0;
    end else begin
      direction_q     <= direction_d;
      alpha_present_q <= alpha_present_d;
    end
  end

  // beat control into the pipeline
  assign ctrl.valid    = start_i && !busy_o;
  assign ctrl.dir      = direction_q;
  assign ctrl.alpha_en = alpha_present_q;

  rgbxyz_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .first_i   (in_first_i),
    .second_i  (in_second_i),
    .third_i   (in_third_i),
    .alpha_i   (in_alpha_i),
    .row_end_i (in_row_end_i),
    .valid_o   (out_valid_o),
    .first_o   (out_first_o),
    .second_o  (out_second_o),
    .third_o   (out_third_o),
    .alpha_o   (out_alpha_o),
    .row_end_o (out_row_end_o)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import rgbxyz_pkg::*;

  // spare register slots and direction codes
  localparam cfg_idx_t CFG_IDX_SPARE_A = 2'd2;
  localparam cfg_idx_t CFG_IDX_SPARE_B = 2'd3;
  localparam logic     DIR_RGB_TO_XYZ  = 1'b0;
  localparam logic     DIR_XYZ_TO_RGB  = 1'b1;
  localparam int       PIPE_SETTLE     = 8;
  localparam int       STALL_LIMIT     = 5000;
  localparam int       RANDOM_PER_SET  = 154;

  typedef struct packed {
    res_t   first;
    res_t   second;
    res_t   third;
    alpha_t alpha;
    logic   row_end;
  } pixel_out_t;

  logic     clk_i        = 1'b0;
  logic     rst_ni       = 1'b0;
  logic     start_i      = 1'b0;
  chan_t    in_first_i   = '0;
  chan_t    in_second_i  = '0;
  chan_t    in_third_i   = '0;
  chan_t    in_alpha_i   = '0;
  logic     in_row_end_i = 1'b0;
  logic     cfg_valid_i  = 1'b0;
  cfg_idx_t cfg_index_i  = '0;
  logic     cfg_data_i   = 1'b0;
  logic     busy_o;
  logic     out_valid_o;
  res_t     out_first_o;
  res_t     out_second_o;
  res_t     out_third_o;
  alpha_t   out_alpha_o;
  logic     out_row_end_o;
  logic     cfg_ready_o;

  // shadow of the block's configuration
  logic model_dir   = DIR_RGB_TO_XYZ;
  logic model_alpha = 1'b0;

  pixel_out_t pending_pixels [$];
  int         mismatch_count  = 0;
  int         sender_idle_pct = 0;
  int         quiet_cycles    = 0;

  rgb16_xyz_color_matrix dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_first_i    (in_first_i),
    .in_second_i   (in_second_i),
    .in_third_i    (in_third_i),
    .in_alpha_i    (in_alpha_i),
    .in_row_end_i  (in_row_end_i),
    .out_valid_o   (out_valid_o),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o),
    .out_third_o   (out_third_o),
    .out_alpha_o   (out_alpha_o),
    .out_row_end_o (out_row_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // matrix entries in millionths, row major
  function automatic longint coef_micro(input logic rev, input int idx);
    longint m;
    if (!rev) begin
      case (idx)
        0: m = 412453;   1: m = 357580;   2: m = 180423;
        3: m = 212671;   4: m = 715160;   5: m = 72169;
        6: m = 19334;    7: m = 119193;   default: m = 950227;
      endcase
    end else begin
      case (idx)
        0: m = 3240479;  1: m = -1537150; 2: m = -498535;
        3: m = -969256;  4: m = 1875991;  5: m = 41556;
        6: m = 55648;    7: m = -204043;  default: m = 1057311;
      endcase
    end
    return m;
  endfunction

  // millionths to fixed point, nearest with ties away from zero
  function automatic longint coef_q(input logic rev, input int idx);
    longint m;
    longint mag;
    longint q;
    m   = coef_micro(rev, idx);
    mag = (m < 0) ? -m : m;
    q   = (mag * (longint'(1) <<< COEF_FRAC_BITS) + 500000) / 1000000;
    return (m < 0) ? -q : q;
  endfunction

  function automatic longint sat16(input longint v);
    return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
  endfunction

  // expected output pixel for the current configuration
  function automatic pixel_out_t convert_pixel(input chan_t c0, input chan_t c1,
                                               input chan_t c2, input chan_t a,
                                               input logic re);
    longint     src [3];
    longint     v;
    longint     acc;
    longint     r;
    res_t       chan_out [3];
    pixel_out_t px;
    src[0] = longint'(c0);
    src[1] = longint'(c1);
    src[2] = longint'(c2);
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        v = model_dir ? src[i] : sat16(src[i]);
        acc += coef_q(model_dir, k * 3 + i) * v;
      end
      // floor of sum plus one half, negatives go to zero
      r = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
      r = (r < 0) ? 0 : (r >>> COEF_FRAC_BITS);
      if (model_dir && r > 65535) r = 65535;
      chan_out[k] = res_t'(r);
    end
    px.first   = chan_out[0];
    px.second  = chan_out[1];
    px.third   = chan_out[2];
    px.alpha   = model_alpha ? alpha_t'(sat16(longint'(a))) : '0;
    px.row_end = re;
    return px;
  endfunction

  // random channel value, weighted toward the valid 16-bit range
  function automatic chan_t rand_chan();
    chan_t v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = chan_t'($urandom_range(65535));
      4, 5:       v = chan_t'($urandom);
      6:          v = chan_t'($urandom_range(75000, 60000));
      7:          v = chan_t'(longint'($urandom_range(2000)) - 1000);
      default: begin
        case ($urandom_range(5))
          0:       v = -18'sd131072;
          1:       v = 18'sd131071;
          2:       v = '0;
          3:       v = chan_t'(65535);
          4:       v = chan_t'(65536);
          default: v = -18'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input chan_t c0, input chan_t c1, input chan_t c2,
                            input chan_t a, input logic re);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start_i      <= 1'b1;
    in_first_i   <= c0;
    in_second_i  <= c1;
    in_third_i   <= c2;
    in_alpha_i   <= a;
    in_row_end_i <= re;
    do @(posedge clk_i); while (busy_o);
    pending_pixels.push_back(convert_pixel(c0, c1, c2, a, re));
  endtask

  task automatic send_random_pixel();
    send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
               logic'($urandom_range(1)));
  endtask

  // hold the sender until the pipeline is empty
  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  // one register beat; the caller lowers the valid afterwards
  task automatic write_reg(input cfg_idx_t idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DIRECTION:     model_dir   = val;
      REG_ALPHA_PRESENT: model_alpha = val;
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic dir, input logic alpha_on);
    drain_pipeline();
    write_reg(REG_DIRECTION, dir);
    write_reg(REG_ALPHA_PRESENT, alpha_on);
    cfg_valid_i <= 1'b0;
  endtask

  // registers after reset: forward direction, alpha output forced to zero
  task automatic test_reset_defaults();
    send_pixel(chan_t'(65535), chan_t'(65535), chan_t'(65535), chan_t'(65535), 1'b1);
    send_pixel(chan_t'(1000), chan_t'(2000), chan_t'(3000), chan_t'(500), 1'b0);
  endtask

  // forward inputs outside 0..65535 are saturated first
  task automatic test_forward_saturation();
    set_mode(DIR_RGB_TO_XYZ, 1'b0);
    send_pixel(-18'sd131072, 18'sd131071, -18'sd1, '0, 1'b0);
    send_pixel(chan_t'(65536), chan_t'(65535), '0, '0, 1'b1);
    send_pixel(-18'sd1, chan_t'(65536), 18'sd131071, '0, 1'b0);
    send_pixel(chan_t'(32768), chan_t'(16384), chan_t'(8192), '0, 1'b1);
  endtask

  // reverse results clamp at both ends
  task automatic test_reverse_clamp();
    set_mode(DIR_XYZ_TO_RGB, 1'b0);
    send_pixel(chan_t'(65535), chan_t'(65535), chan_t'(65535), '0, 1'b0);
    send_pixel('0, chan_t'(65535), '0, '0, 1'b1);
    send_pixel(18'sd131071, -18'sd131072, 18'sd131071, '0, 1'b0);
    send_pixel(-18'sd131072, 18'sd131071, -18'sd131072, '0, 1'b1);
    send_pixel(chan_t'(1), chan_t'(1), chan_t'(1), '0, 1'b0);
    send_pixel(chan_t'(65535), '0, '0, '0, 1'b0);
    send_pixel('0, '0, chan_t'(65535), '0, 1'b1);
  endtask

  // alpha is clamped in both directions when enabled
  task automatic test_alpha_clamp();
    set_mode(DIR_RGB_TO_XYZ, 1'b1);
    send_pixel(chan_t'(100), chan_t'(200), chan_t'(300), -18'sd131072, 1'b0);
    send_pixel(chan_t'(100), chan_t'(200), chan_t'(300), -18'sd1, 1'b1);
    send_pixel(chan_t'(100), chan_t'(200), chan_t'(300), '0, 1'b0);
    send_pixel(chan_t'(100), chan_t'(200), chan_t'(300), chan_t'(65535), 1'b1);
    send_pixel(chan_t'(100), chan_t'(200), chan_t'(300), chan_t'(65536), 1'b0);
    send_pixel(chan_t'(100), chan_t'(200), chan_t'(300), 18'sd131071, 1'b1);
    set_mode(DIR_XYZ_TO_RGB, 1'b1);
    send_pixel(chan_t'(20000), chan_t'(30000), chan_t'(40000), chan_t'(40000), 1'b0);
    send_pixel(chan_t'(20000), chan_t'(30000), chan_t'(40000), -18'sd5, 1'b1);
  endtask

  // writes to indexes past the last register leave the setup alone
  task automatic test_spare_registers();
    drain_pipeline();
    write_reg(CFG_IDX_SPARE_A, 1'b0);
    write_reg(CFG_IDX_SPARE_B, 1'b1);
    cfg_valid_i <= 1'b0;
    send_pixel(chan_t'(50000), chan_t'(10000), chan_t'(5000), chan_t'(1234), 1'b0);
    send_pixel(chan_t'(70000), chan_t'(-300), chan_t'(9), chan_t'(99999), 1'b1);
  endtask

  // random pixels through every setting under three sender idle patterns
  task automatic test_random_stream();
    int idle_pct [3];
    idle_pct[0] = 30;
    idle_pct[1] = 78;
    idle_pct[2] = 0;
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_pct[ph];
      for (int m = 0; m < 4; m++) begin
        set_mode(logic'(m[1]), logic'(m[0]));
        repeat (RANDOM_PER_SET) send_random_pixel();
      end
    end
    sender_idle_pct = 0;
  endtask

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint got_v);
    if (exp_v != got_v) begin
      $error("%s expected %0d got %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // compare every result beat against the oldest prediction
  always @(posedge clk_i) begin
    pixel_out_t exp_px;
    if (rst_ni && out_valid_o) begin
      if (pending_pixels.size() == 0) begin
        $error("result beat with no pixel outstanding");
        mismatch_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        check_field("out_first", longint'(exp_px.first), longint'(out_first_o));
        check_field("out_second", longint'(exp_px.second), longint'(out_second_o));
        check_field("out_third", longint'(exp_px.third), longint'(out_third_o));
        check_field("out_alpha", longint'(exp_px.alpha), longint'(out_alpha_o));
        check_field("out_row_end", longint'(exp_px.row_end), longint'(out_row_end_o));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || out_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_forward_saturation();
    test_reverse_clamp();
    test_alpha_clamp();
    test_spare_registers();
    test_random_stream();
    drain_pipeline();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
